// ===== design/hbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbcs_pkg
// Types and constants shared by the host bridge configuration space block.
// ----------------------------------------------------------------------------
package hbcs_pkg;

    // Access kinds carried in the action field.
    localparam logic ACTION_READ  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    // The only implemented PCI function.
    localparam logic [2:0] FUNC_HOST = 3'd0;

    // SMRAM segment addresses and window sizes.
    localparam logic [19:0] SMRAM_SEG_A    = 20'hA0000;
    localparam logic [19:0] SMRAM_SEG_B    = 20'hB0000;
    localparam logic [19:0] SMRAM_SEG_E    = 20'hE0000;
    localparam logic [16:0] SMRAM_SIZE_32K = 17'h08000;
    localparam logic [16:0] SMRAM_SIZE_64K = 17'h10000;

    // SMRAM modes in bits 7-5 of register 0x65.
    localparam logic [2:0] SMRAM_MODE_FIXED_E = 3'd0;
    localparam logic [2:0] SMRAM_MODE_B_64K   = 3'd1;
    localparam logic [2:0] SMRAM_MODE_A_64K   = 3'd2;
    localparam logic [2:0] SMRAM_MODE_A_32K   = 3'd4;
    localparam logic [2:0] SMRAM_MODE_BA_32K  = 3'd6;

    typedef struct packed {
        logic       action;
        logic [2:0] func_number;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
    } hbcs_req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        smi_fired;
        logic [12:0] read_internal_mask;
        logic [12:0] write_internal_mask;
        logic        ext_cache_enable;
        logic        fast_reset_enable;
        logic [1:0]  smram_windows;
        logic [30:0] smram_host_base;
        logic [19:0] smram_target_first;
        logic [19:0] smram_target_second;
        logic [16:0] smram_size;
        logic        smram_smm_only;
    } hbcs_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_RESPOND
    } hbcs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic access;
        logic respond;
    } hbcs_cmd_t;

endpackage

// ===== design/hbcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbcs_ctrl
// Sequencer: takes an item, runs the register access, then loads the result.
// ----------------------------------------------------------------------------
module hbcs_ctrl
    import hbcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output hbcs_cmd_t cmd
);

    hbcs_state_t state_reg;
    hbcs_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_stall   = 1'b1;
        // A waiting result leaves once the consumer takes it.
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.respond    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result register loaded while a result was still waiting");

    a_respond_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |=> rsp_valid_reg)
        else $error("loaded result was not presented");

    a_capture_then_access: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.access)
        else $error("captured item was not processed in the next cycle");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.access, cmd.respond}))
        else $error("more than one datapath command at once");
`endif

endmodule

// ===== design/hbcs_datapath.sv =====
// ----------------------------------------------------------------------------
// hbcs_datapath
// Configuration registers, masked write logic, read mux and state decode.
// ----------------------------------------------------------------------------
module hbcs_datapath
    import hbcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hbcs_cmd_t cmd,
    input  hbcs_req_t req,
    input  logic      cfg_write_en,
    input  logic      cfg_write_data,
    output hbcs_rsp_t rsp
);

    // Offsets within the 0x50-0x6F bank.
    localparam logic [4:0] IDX_51 = 5'h01;
    localparam logic [4:0] IDX_53 = 5'h03;
    localparam logic [4:0] IDX_54 = 5'h04;
    localparam logic [4:0] IDX_55 = 5'h05;
    localparam logic [4:0] IDX_56 = 5'h06;
    localparam logic [4:0] IDX_5B = 5'h0B;
    localparam logic [4:0] IDX_60 = 5'h10;
    localparam logic [4:0] IDX_64 = 5'h14;
    localparam logic [4:0] IDX_65 = 5'h15;
    localparam logic [4:0] IDX_68 = 5'h18;
    localparam logic [4:0] IDX_69 = 5'h19;

    hbcs_req_t   req_reg;
    logic        variant_reg;
    logic [7:0]  r04_reg;
    logic [7:0]  r04_next;
    logic [7:0]  r07_reg;
    logic [7:0]  r07_next;
    logic [7:0]  bank_reg [32];
    logic [7:0]  bank_next [32];
    logic [7:0]  ext_reg [8];
    logic [7:0]  ext_next [8];
    logic [7:0]  rdata_reg;
    logic [7:0]  rdata_next;
    logic        smi_reg;
    logic        smi_next;
    hbcs_rsp_t   rsp_reg;
    hbcs_rsp_t   rsp_next;

    logic        write_go;
    logic [4:0]  bank_idx;
    logic [2:0]  ext_idx;
    logic [7:0]  wdata;

    assign write_go = cmd.access && (req_reg.action == ACTION_WRITE)
                      && (req_reg.func_number == FUNC_HOST);
    // Offset from 0x50 within the bank: bit 4 flips, the low nibble passes.
    assign bank_idx = {~req_reg.reg_addr[4], req_reg.reg_addr[3:0]};
    assign ext_idx  = req_reg.reg_addr[2:0];
    assign wdata    = req_reg.write_data;

    // Register write path.
    always_comb
    begin
        r04_next  = r04_reg;
        r07_next  = r07_reg;
        bank_next = bank_reg;
        ext_next  = ext_reg;
        smi_next  = 1'b0;
        if (write_go)
        begin
            case (req_reg.reg_addr) inside
                8'h04:
                begin
                    r04_next = (r04_reg & 8'hB4) | (wdata & 8'h4B);
                end
                8'h07:
                begin
                    // Status bits 3-7 clear when written with one.
                    r07_next = ((r07_reg & 8'hF9) & ~(wdata & 8'hF8)) | (wdata & 8'h06);
                end
                8'h50:
                begin
                    bank_next[bank_idx] = variant_reg ? (wdata & 8'hF7) : wdata;
                end
                [8'h51:8'h5E], [8'h61:8'h65], 8'h67, 8'h68, [8'h6A:8'h6F]:
                begin
                    bank_next[bank_idx] = wdata;
                end
                8'h5F:
                begin
                    bank_next[bank_idx] = wdata & 8'hFE;
                end
                8'h60:
                begin
                    // SMI fires on a rising edge of bit 1 while 0x68 bit 0 is set.
                    if (bank_reg[IDX_68][0] && !bank_reg[IDX_60][1] && wdata[1])
                    begin
                        bank_next[IDX_69][0] = 1'b1;
                        smi_next             = 1'b1;
                    end
                    bank_next[bank_idx] = wdata & 8'h3E;
                end
                8'h66:
                begin
                    bank_next[bank_idx] = wdata & 8'h7F;
                end
                8'h69:
                begin
                    bank_next[bank_idx] = bank_reg[bank_idx] & ~wdata;
                end
                8'h78, [8'h7C:8'h7E]:
                begin
                    if (variant_reg)
                    begin
                        ext_next[ext_idx] = wdata;
                    end
                end
                8'h7A:
                begin
                    if (variant_reg)
                    begin
                        ext_next[ext_idx] = wdata & 8'hFE;
                    end
                end
                8'h7B:
                begin
                    if (variant_reg)
                    begin
                        ext_next[ext_idx] = wdata & 8'hE0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read path; writes return zero.
    always_comb
    begin
        rdata_next = 8'h00;
        if (req_reg.action == ACTION_READ)
        begin
            if (req_reg.func_number != FUNC_HOST)
            begin
                rdata_next = 8'hFF;
            end
            else
            begin
                case (req_reg.reg_addr) inside
                    8'h00:          rdata_next = 8'h39;
                    8'h01:          rdata_next = 8'h10;
                    8'h02:          rdata_next = 8'h06;
                    8'h03:          rdata_next = 8'h04;
                    8'h04:          rdata_next = r04_reg;
                    8'h07:          rdata_next = r07_reg;
                    8'h0B:          rdata_next = 8'h06;
                    [8'h50:8'h6F]:  rdata_next = bank_reg[bank_idx];
                    [8'h78:8'h7F]:  rdata_next = ext_reg[ext_idx];
                    default:        rdata_next = 8'h00;
                endcase
            end
        end
    end

    // Decode of routing and SMRAM state from the current register contents.
    always_comb
    begin
        logic        rd_int;
        logic        wr_int;
        logic [7:0]  r65;
        logic [30:0] host;
        logic [2:0]  mode;

        rd_int = bank_reg[IDX_53][6];
        wr_int = !bank_reg[IDX_53][5];
        r65    = bank_reg[IDX_65];
        host   = {r65[2:0], bank_reg[IDX_64], 20'h00000};
        mode   = r65[7:5];

        rsp_next           = '0;
        rsp_next.read_data = rdata_reg;
        rsp_next.smi_fired = smi_reg;

        rsp_next.read_internal_mask[12]  = rd_int;
        rsp_next.write_internal_mask[12] = wr_int;
        for (int i = 0; i < 4; i++)
        begin
            rsp_next.read_internal_mask[i]      = bank_reg[IDX_56][7 - i] & rd_int;
            rsp_next.write_internal_mask[i]     = bank_reg[IDX_56][7 - i] & wr_int;
            rsp_next.read_internal_mask[4 + i]  = bank_reg[IDX_55][7 - i] & rd_int;
            rsp_next.write_internal_mask[4 + i] = bank_reg[IDX_55][7 - i] & wr_int;
            rsp_next.read_internal_mask[8 + i]  = bank_reg[IDX_54][7 - i] & rd_int;
            rsp_next.write_internal_mask[8 + i] = bank_reg[IDX_54][7 - i] & wr_int;
        end

        rsp_next.ext_cache_enable  = bank_reg[IDX_51][6];
        rsp_next.fast_reset_enable = bank_reg[IDX_5B][6];

        if (mode == SMRAM_MODE_FIXED_E)
        begin
            rsp_next.smram_windows      = 2'd1;
            rsp_next.smram_host_base    = {11'd0, SMRAM_SEG_E};
            rsp_next.smram_target_first = SMRAM_SEG_E;
            rsp_next.smram_size         = SMRAM_SIZE_32K;
        end
        else if (host != '0)
        begin
            case (mode)
                SMRAM_MODE_B_64K:
                begin
                    rsp_next.smram_windows       = 2'd2;
                    rsp_next.smram_host_base     = host | {11'd0, SMRAM_SEG_B};
                    rsp_next.smram_target_first  = SMRAM_SEG_B;
                    rsp_next.smram_target_second = SMRAM_SEG_B;
                    rsp_next.smram_size          = SMRAM_SIZE_64K;
                end
                SMRAM_MODE_A_64K:
                begin
                    rsp_next.smram_windows       = 2'd2;
                    rsp_next.smram_host_base     = host | {11'd0, SMRAM_SEG_A};
                    rsp_next.smram_target_first  = SMRAM_SEG_A;
                    rsp_next.smram_target_second = SMRAM_SEG_A;
                    rsp_next.smram_size          = SMRAM_SIZE_64K;
                end
                SMRAM_MODE_A_32K:
                begin
                    rsp_next.smram_windows       = 2'd2;
                    rsp_next.smram_host_base     = host | {11'd0, SMRAM_SEG_A};
                    rsp_next.smram_target_first  = SMRAM_SEG_A;
                    rsp_next.smram_target_second = SMRAM_SEG_A;
                    rsp_next.smram_size          = SMRAM_SIZE_32K;
                end
                SMRAM_MODE_BA_32K:
                begin
                    rsp_next.smram_windows       = 2'd2;
                    rsp_next.smram_host_base     = host | {11'd0, SMRAM_SEG_B};
                    rsp_next.smram_target_first  = SMRAM_SEG_B;
                    rsp_next.smram_target_second = SMRAM_SEG_A;
                    rsp_next.smram_size          = SMRAM_SIZE_32K;
                end
                default:
                begin
                end
            endcase
        end

        rsp_next.smram_smm_only = (rsp_next.smram_windows != 2'd0) ? r65[4] : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= 1'b0;
            r04_reg     <= 8'h04;
            r07_reg     <= 8'h04;
            for (int i = 0; i < 32; i++)
            begin
                bank_reg[i] <= 8'h00;
            end
            for (int i = 0; i < 8; i++)
            begin
                ext_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                variant_reg <= cfg_write_data;
            end
            r04_reg  <= r04_next;
            r07_reg  <= r07_next;
            bank_reg <= bank_next;
            ext_reg  <= ext_next;
        end
    end

    // Item, access results and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.access)
        begin
            rdata_reg <= rdata_next;
            smi_reg   <= smi_next;
        end
        if (cmd.respond)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== design/host_bridge_config_space.sv =====
// An accepted item is captured, its register access is registered, and its
// result is then loaded into the output register. The three-state sequencer
// takes no new item until it is back in idle, and a result the consumer
// stalls holds it in its result state until the output register frees up.
// Reset (rst_n low, asynchronous): registers return to their power-on values,
// the variant select clears and no result is pending.
// ----------------------------------------------------------------------------
// host_bridge_config_space
// Function 0 configuration space of a host bridge, one byte access per item.
// ----------------------------------------------------------------------------
module host_bridge_config_space
    import hbcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  hbcs_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output hbcs_rsp_t rsp,
    input  logic      cfg_write_en,
    input  logic      cfg_write_data
);

    hbcs_cmd_t cmd;

    hbcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    hbcs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .req            (req),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .rsp            (rsp)
    );

endmodule
